@@ hw/rtl/assert_macros.svh @@
// assertion macros included by the tlb top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property with an implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/fatlb_pkg.sv @@
// types and constants of the fully associative tlb
package fatlb_pkg;

  localparam int unsigned VpnW  = 27;
  localparam int unsigned AsidW = 16;
  localparam int unsigned PpnW  = 44;
  localparam int unsigned PaW   = 56;

  typedef enum logic [1:0] {
    ActTranslate = 2'd0,
    ActInsert    = 2'd1,
    ActFlush     = 2'd2,
    ActNone      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StMiss  = 2'd1,
    StRewalk = 2'd2,
    StFault = 2'd3
  } status_e;

  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindExec  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [38:0] virt_addr;
    logic [15:0] asid;
    logic [1:0]  access_kind;
    logic        priv_mode;
    logic [43:0] phys_page;
    logic [1:0]  page_level;
    logic [3:0]  pte_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  fault_cause;
    logic [55:0] phys_addr;
  } rsp_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              touch;    // make the hit cell most recent
    logic              upd_flags; // overwrite flags of the hit cell
    logic              alloc;    // write the new entry into the chosen cell
    logic              flush;    // sfence
    logic              close;    // close ranks after a removal
    logic              flush_all_va;
    logic              flush_all_as;
    logic [VpnW-1:0]   vpn;
    logic [AsidW-1:0]  asid;
    logic [PpnW-1:0]   ppn;
    logic [1:0]        level;
    logic [3:0]        flags;
  } cell_cmd_t;

  // vpn mask keeping the bits above the page size
  function automatic logic [VpnW-1:0] lvl_mask(input logic [1:0] lvl);
    case (lvl)
      2'd0:    lvl_mask = {VpnW{1'b1}};
      2'd1:    lvl_mask = {{(VpnW-9){1'b1}}, 9'd0};
      default: lvl_mask = {{(VpnW-18){1'b1}}, 18'd0};
    endcase
  endfunction

endpackage

@@ hw/rtl/fatlb_cell.sv @@
// one tlb entry with its tag, payload and lru rank
module fatlb_cell #(
  parameter int unsigned AgeW = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fatlb_pkg::cell_cmd_t  cmd_i,
  input  logic                  sel_i,      // this cell is the hit or victim
  input  logic [AgeW-1:0]       ref_age_i,  // rank of the touched or removed cell
  input  logic                  ref_valid_i, // a removed cell was valid
  output logic                  valid_o,
  output logic                  match_o,
  output logic [1:0]            level_o,
  output logic [3:0]            flags_o,
  output logic [fatlb_pkg::PpnW-1:0] ppn_o,
  output logic [AgeW-1:0]       age_o,
  output logic                  fl_hit_o    // flush removes this cell
);
  import fatlb_pkg::*;

  logic              valid_q, valid_d;
  logic [VpnW-1:0]   vpn_q;
  logic [AsidW-1:0]  asid_q;
  logic [PpnW-1:0]   ppn_q;
  logic [1:0]        level_q;
  logic [3:0]        flags_q;
  logic [AgeW-1:0]   age_q, age_d;
  logic              va_eq;

  // compare the vpn bits above this entry's page size
  assign va_eq    = ((vpn_q ^ cmd_i.vpn) & lvl_mask(level_q)) == '0;
  assign match_o  = valid_q && (asid_q == cmd_i.asid) && va_eq;
  assign fl_hit_o = valid_q && (cmd_i.flush_all_va || va_eq) &&
                    (cmd_i.flush_all_as || asid_q == cmd_i.asid);
  assign valid_o  = valid_q;
  assign level_o  = level_q;
  assign flags_o  = flags_q;
  assign ppn_o    = ppn_q;
  assign age_o    = age_q;

  // validity and rank update
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    if (cmd_i.touch) begin
      if (sel_i) age_d = '0;
      else if (valid_q && age_q < ref_age_i) age_d = age_q + 1'b1;
    end else if (cmd_i.alloc) begin
      if (sel_i) begin
        valid_d = 1'b1;
        age_d   = '0;
      end else if (valid_q) begin
        // a removed victim shifts the older entries down first
        if (ref_valid_i && age_q > ref_age_i) age_d = age_q;
        else age_d = age_q + 1'b1;
      end
    end else if (cmd_i.flush) begin
      if (fl_hit_o) valid_d = 1'b0;
    end else if (cmd_i.close) begin
      // flushed entries still waiting to close shift too, keeping their rank
      if (sel_i) valid_d = 1'b0;
      else if (age_q > ref_age_i) age_d = age_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc && sel_i) begin
      vpn_q   <= cmd_i.vpn & lvl_mask(cmd_i.level);
      asid_q  <= cmd_i.asid;
      ppn_q   <= cmd_i.ppn;
      level_q <= cmd_i.level;
      flags_q <= cmd_i.flags;
    end else if (cmd_i.upd_flags && sel_i) begin
      flags_q <= cmd_i.flags;
    end
  end

endmodule

@@ hw/rtl/fully_assoc_tlb_lru.sv @@
// top level of the fully associative sv39 tlb with true lru replacement
// A translate or an insert passes the look, decide and response states before
// the result strobe; a flush also passes the close state after decide, where
// the lru ranks are closed up one removed entry per cycle.
// busy is high from start through the strobe cycle, so the next item is taken
// in the cycle after the strobe at the earliest, and no item is taken while
// another is in flight. The receiver cannot stall, and every item gives
// exactly one result. The entries form a row of cells that compare in
// parallel; the hit is the matching cell with the smallest page, lowest index
// first; an insert that misses fills the lowest free cell, else the oldest rank.
module fully_assoc_tlb_lru #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fatlb_pkg::req_t   req_i,
  output logic              done_o,
  output fatlb_pkg::rsp_t   rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);
  import fatlb_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned AgeW = IdxW;

  typedef enum logic [2:0] {
    SIdle, SLook, SDecide, SClose, SResp
  } state_e;

  state_e          state_q;
  req_t            req_q;
  logic            sum_q;
  cell_cmd_t       cmd;
  logic [ENTRIES-1:0] sel, valid, match, fl_hit, match_q, fl_q;
  logic [ENTRIES-1:0] hit_l0, hit_l1, hit_vec, lru_vec;
  logic [1:0]      level   [ENTRIES];
  logic [3:0]      flags   [ENTRIES];
  logic [PpnW-1:0] ppn     [ENTRIES];
  logic [AgeW-1:0] age     [ENTRIES];
  logic [AgeW-1:0] ref_age;
  logic            ref_valid;
  logic [IdxW-1:0] hit_idx, free_idx, lru_idx;
  logic            hit_any, free_any;
  logic [1:0]      kind, lvl_in;
  rsp_t            rsp_q;
  logic            done_q;
  logic [VpnW-1:0] vpn_in;

  assign vpn_in = req_q.virt_addr[38:12];
  assign kind   = (req_q.access_kind == 2'd3) ? KindExec : req_q.access_kind;
  assign lvl_in = (req_q.page_level == 2'd3) ? 2'd2 : req_q.page_level;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sum_q <= 1'b0;
    else if (cfg_valid_i) sum_q <= cfg_data_i;
  end

  // row of cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    fatlb_cell #(.AgeW(AgeW)) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd), .sel_i(sel[g]), .ref_age_i(ref_age),
      .ref_valid_i(ref_valid), .valid_o(valid[g]), .match_o(match[g]),
      .level_o(level[g]), .flags_o(flags[g]), .ppn_o(ppn[g]), .age_o(age[g]),
      .fl_hit_o(fl_hit[g]));
  end

  // smallest matching page, lowest free slot and lru victim
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_l0[i]  = match_q[i] && (level[i] == 2'd0);
      hit_l1[i]  = match_q[i] && (level[i] == 2'd1);
      // ranks of a full row run from zero to the last entry
      lru_vec[i] = valid[i] && (age[i] == AgeW'(ENTRIES - 1));
    end
    if (|hit_l0) hit_vec = hit_l0;
    else if (|hit_l1) hit_vec = hit_l1;
    else hit_vec = match_q;
    hit_any  = |match_q;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
      if (hit_vec[i]) hit_idx = IdxW'(i);
      if (lru_vec[i]) lru_idx = IdxW'(i);
    end
  end

  // lowest flagged entry still to close
  logic [IdxW-1:0] fl_idx;
  logic            fl_any;
  always_comb begin
    fl_any = 1'b0;
    fl_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (fl_q[i]) begin
        fl_any = 1'b1;
        fl_idx = IdxW'(i);
      end
    end
  end

  // cell command
  always_comb begin
    cmd = '0;
    cmd.vpn   = vpn_in;
    cmd.asid  = req_q.asid;
    cmd.ppn   = req_q.phys_page;
    cmd.level = lvl_in;
    cmd.flags = req_q.pte_flags;
    cmd.flush_all_va = req_q.virt_addr == '0;
    cmd.flush_all_as = req_q.asid == '0;
    sel       = '0;
    ref_age   = '0;
    ref_valid = 1'b0;
    if (state_q == SDecide) begin
      case (action_e'(req_q.action))
        ActTranslate: if (hit_any) begin
          cmd.touch = 1'b1;
          sel[hit_idx] = 1'b1;
          ref_age = age[hit_idx];
        end
        ActInsert: begin
          if (hit_any) begin
            cmd.upd_flags = 1'b1;
            sel[hit_idx] = 1'b1;
          end else begin
            cmd.alloc = 1'b1;
            if (free_any) sel[free_idx] = 1'b1;
            else begin
              sel[lru_idx] = 1'b1;
              ref_age   = age[lru_idx];
              ref_valid = 1'b1;
            end
          end
        end
        ActFlush: cmd.flush = 1'b1;
        default: ;
      endcase
    end else if (state_q == SClose && fl_any) begin
      cmd.close = 1'b1;
      sel[fl_idx] = 1'b1;
      ref_age = age[fl_idx];
    end
  end

  // result of a translate
  rsp_t    tr_rsp;
  logic [3:0] f;
  logic [PaW-1:0] om;
  always_comb begin
    tr_rsp = '0;
    f  = flags[hit_idx];
    om = '0;
    case (level[hit_idx])
      2'd0:    om = PaW'(12'hfff);
      2'd1:    om = PaW'(21'h1fffff);
      default: om = PaW'(30'h3fffffff);
    endcase
    if (!hit_any) tr_rsp.status = StMiss;
    else if (kind == KindWrite && !f[1]) tr_rsp.status = StRewalk;
    else if ((kind == KindRead && !f[0]) || (kind == KindExec && !f[2]) ||
             (!req_q.priv_mode && !f[3]) ||
             (req_q.priv_mode && f[3] && (kind == KindExec || !sum_q))) begin
      tr_rsp.status = StFault;
      tr_rsp.fault_cause = kind;
    end else begin
      tr_rsp.phys_addr = ({ppn[hit_idx], 12'd0} & ~om) |
                         (PaW'(req_q.virt_addr) & om);
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      done_q    <= 1'b0;
      match_q   <= '0;
      fl_q      <= '0;
      rsp_q     <= '0;
    end else begin
      done_q <= (state_q == SResp);
      case (state_q)
        SIdle: if (start && !busy) state_q <= SLook;
        SLook: begin
          match_q <= match;
          state_q <= SDecide;
        end
        SDecide: begin
          rsp_q <= (action_e'(req_q.action) == ActTranslate) ? tr_rsp : rsp_t'('0);
          if (action_e'(req_q.action) == ActFlush) begin
            fl_q    <= fl_hit;
            state_q <= SClose;
          end else state_q <= SResp;
        end
        SClose: begin
          // flushed cells are already invalid; close their ranks one a cycle
          if (fl_any) fl_q[fl_idx] <= 1'b0;
          else state_q <= SResp;
        end
        SResp: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
  end

  assign busy   = (state_q != SIdle) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ASSERT_IMPLY(a_done_one, clk_i, rst_ni, done_q, !done_q, "double result strobe")
  `ASSERT_ALWAYS(a_fault_cause, clk_i, rst_ni,
    !done_q || rsp_q.status == StFault || rsp_q.fault_cause == 2'd0, "stray cause")
  `ASSERT_ALWAYS(a_sel_onehot, clk_i, rst_ni, $onehot0(sel), "several cells selected")

endmodule
